[design/tafd_pkg.sv]
// Shared types and constants for the tagged accelerometer FIFO decoder.
package tafd_pkg;

  localparam int unsigned TagWidth   = 8;
  localparam int unsigned KindWidth  = 5;
  localparam int unsigned KindShift  = 3;
  localparam int unsigned AxisWidth  = 16;
  localparam int unsigned TsWidth    = 32;
  localparam int unsigned GainWidth  = 32;
  localparam int unsigned AccelWidth = 48;
  localparam int unsigned TimeWidth  = 64;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [KindWidth-1:0] KIND_ACCEL = 5'h02;
  localparam logic [KindWidth-1:0] KIND_TEMP  = 5'h03;
  localparam logic [KindWidth-1:0] KIND_TIME  = 5'h04;

  localparam logic [CfgIdxWidth-1:0] REG_ACCEL_GAIN   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_TIME_GAIN    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SAMPLE_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    STATUS_SAMPLE      = 2'd0,
    STATUS_TEMP_ERR    = 2'd1,
    STATUS_INVALID_TAG = 2'd2
  } status_t;

  // One queued job for the arithmetic side; error jobs carry zero operands.
  typedef struct packed {
    status_t               status;
    logic [AxisWidth-1:0]  x;
    logic [AxisWidth-1:0]  y;
    logic [AxisWidth-1:0]  z;
    logic [TsWidth-1:0]    diff;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic halted;
  } fe_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[design/tafd_front.sv]
// Record classifier and decoder state: turns accepted records into queued jobs.
module tafd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [tafd_pkg::TagWidth-1:0]   tag_byte,
  input  logic [7:0]                      byte1,
  input  logic [7:0]                      byte2,
  input  logic [7:0]                      byte3,
  input  logic [7:0]                      byte4,
  input  logic [7:0]                      byte5,
  input  logic [7:0]                      byte6,
  input  logic [tafd_pkg::TsWidth-1:0]    sample_limit,
  output tafd_pkg::cmd_t                  cmd,
  output tafd_pkg::fe_stat_t              stat
);
  import tafd_pkg::*;

  logic [TsWidth-1:0]   latest_timestamp, latest_timestamp_next;
  logic [TsWidth-1:0]   base_timestamp, base_timestamp_next;
  logic                 accel_blocked, accel_blocked_next;
  logic [TsWidth-1:0]   records_seen, records_seen_next;
  logic                 halted, halted_next;
  logic                 push;
  logic [KindWidth-1:0] kind;
  logic [TsWidth-1:0]   stamp;
  logic                 live;

  assign kind  = tag_byte[TagWidth-1:KindShift];
  assign stamp = {byte4, byte3, byte2, byte1};
  assign live  = accept && !halted && (records_seen < sample_limit);

  always_comb begin
    latest_timestamp_next = latest_timestamp;
    base_timestamp_next   = base_timestamp;
    accel_blocked_next    = accel_blocked;
    records_seen_next     = records_seen;
    halted_next           = halted;
    push                  = 1'b0;
    cmd                   = '0;
    cmd.status            = STATUS_SAMPLE;
    if (live) begin
      records_seen_next = records_seen + 32'd1;
      if (kind == KIND_ACCEL) begin
        if (!accel_blocked) begin
          push               = 1'b1;
          cmd.x              = {byte2, byte1};
          cmd.y              = {byte4, byte3};
          cmd.z              = {byte6, byte5};
          cmd.diff           = latest_timestamp - base_timestamp;
          accel_blocked_next = 1'b1;
        end
      end else if (kind == KIND_TIME) begin
        latest_timestamp_next = stamp;
        if (base_timestamp == '0) begin
          base_timestamp_next = stamp;
        end
        accel_blocked_next = 1'b0;
      end else begin
        // Temperature or unknown record: report and stop.
        push        = 1'b1;
        cmd.status  = (kind == KIND_TEMP) ? STATUS_TEMP_ERR : STATUS_INVALID_TAG;
        halted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest_timestamp <= '0;
      base_timestamp   <= '0;
      accel_blocked    <= 1'b1;
      records_seen     <= '0;
      halted           <= 1'b0;
    end else begin
      latest_timestamp <= latest_timestamp_next;
      base_timestamp   <= base_timestamp_next;
      accel_blocked    <= accel_blocked_next;
      records_seen     <= records_seen_next;
      halted           <= halted_next;
    end
  end

  assign stat.push   = push;
  assign stat.halted = halted;

endmodule

[design/tafd_queue.sv]
// Short job queue between the classifier and the arithmetic side.
module tafd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tafd_pkg::cmd_t  wr_data,
  input  logic            pop,
  output tafd_pkg::cmd_t  rd_data,
  output tafd_pkg::q_stat_t stat
);
  import tafd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/tafd_back.sv]
// Arithmetic side: scale the axes and elapsed time, then hold the result beat.
module tafd_back (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [tafd_pkg::GainWidth-1:0]          accel_gain,
  input  logic [tafd_pkg::GainWidth-1:0]          time_gain,
  input  tafd_pkg::cmd_t                          q_cmd,
  input  tafd_pkg::q_stat_t                       q_stat,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output tafd_pkg::status_t                       out_status,
  output logic signed [tafd_pkg::AccelWidth-1:0]  out_x,
  output logic signed [tafd_pkg::AccelWidth-1:0]  out_y,
  output logic signed [tafd_pkg::AccelWidth-1:0]  out_z,
  output logic [tafd_pkg::TimeWidth-1:0]          out_time
);
  import tafd_pkg::*;

  logic                         p_valid;
  status_t                      p_status;
  logic signed [AccelWidth-1:0] p_x, p_y, p_z;
  logic [TimeWidth-1:0]         p_time;
  logic                         out_free, p_load;
  logic signed [GainWidth:0]    gain_s;
  logic signed [AccelWidth:0]   mul_x, mul_y, mul_z;
  logic [TimeWidth-1:0]         mul_t;

  assign out_free = !out_valid || out_ready;
  assign p_load   = !p_valid || out_free;
  assign pop      = p_load && !q_stat.empty;

  assign gain_s = $signed({1'b0, accel_gain});
  assign mul_x  = $signed(q_cmd.x) * gain_s;
  assign mul_y  = $signed(q_cmd.y) * gain_s;
  assign mul_z  = $signed(q_cmd.z) * gain_s;
  assign mul_t  = {{(TimeWidth-TsWidth){1'b0}}, q_cmd.diff} *
                  {{(TimeWidth-GainWidth){1'b0}}, time_gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_load) begin
        p_valid <= !q_stat.empty;
      end
      if (out_free) begin
        out_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_status <= q_cmd.status;
      p_x      <= mul_x[AccelWidth-1:0];
      p_y      <= mul_y[AccelWidth-1:0];
      p_z      <= mul_z[AccelWidth-1:0];
      p_time   <= mul_t;
    end
    if (out_free && p_valid) begin
      out_status <= p_status;
      out_x      <= p_x;
      out_y      <= p_y;
      out_z      <= p_z;
      out_time   <= p_time;
    end
  end

endmodule

[design/tagged_accel_fifo_decoder_top.sv]
// Top level of the tagged accelerometer FIFO record decoder.
// Each input beat is one 7-byte FIFO record. The record kind is the tag byte
// shifted right by three: a timestamp record loads the latest timestamp (the
// first nonzero one also sets the base) and arms one accelerometer record; an
// accelerometer record that directly follows a timestamp produces a sample beat
// with the three sign-extended axes times accel_gain and the wrapped elapsed
// ticks times time_gain, all exact Q.32 products. A temperature or unknown
// record produces one error beat with zero data and halts the block until
// reset; records beyond sample_limit are dropped silently. The block takes one
// record per clock while the job queue has room: the classifier updates its
// state in the cycle of the beat and queues a job, the multiplier stage
// registers the products, and the output register presents the result.
// s_axis_tready drops only when the QUEUE_DEPTH-entry job queue is full, which
// happens only under sustained back-pressure on the master side. Write the
// configuration registers only while the block is idle; cfg_ready is always
// high and writes to index 3 are ignored.
module tagged_accel_fifo_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // Record input.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // byte1[7:0], byte2[15:8], byte3[23:16], byte4[31:24], byte5[39:32],
  // byte6[47:40]
  input  logic [47:0]  s_axis_tdata,
  // tag_byte[7:0]
  input  logic [7:0]   s_axis_tuser,
  // Result output.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accel_x[47:0], accel_y[95:48], accel_z[143:96], elapsed_time[207:144]
  output logic [207:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser
);
  import tafd_pkg::*;

  logic [GainWidth-1:0] accel_gain, time_gain;
  logic [TsWidth-1:0]   sample_limit;

  fe_stat_t fe_stat;
  q_stat_t  q_stat;
  cmd_t     fe_cmd, q_cmd;
  logic     accept, pop;

  status_t                      out_status;
  logic signed [AccelWidth-1:0] out_x, out_y, out_z;
  logic [TimeWidth-1:0]         out_time;

  // Configuration registers: always ready, unknown indexes dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain   <= '0;
      time_gain    <= '0;
      sample_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACCEL_GAIN:   accel_gain   <= cfg_data;
        REG_TIME_GAIN:    time_gain    <= cfg_data;
        REG_SAMPLE_LIMIT: sample_limit <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Hold the input side only while the job queue has no room.
  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tafd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .tag_byte     (s_axis_tuser),
    .byte1        (s_axis_tdata[7:0]),
    .byte2        (s_axis_tdata[15:8]),
    .byte3        (s_axis_tdata[23:16]),
    .byte4        (s_axis_tdata[31:24]),
    .byte5        (s_axis_tdata[39:32]),
    .byte6        (s_axis_tdata[47:40]),
    .sample_limit (sample_limit),
    .cmd          (fe_cmd),
    .stat         (fe_stat)
  );

  tafd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fe_stat.push),
    .wr_data (fe_cmd),
    .pop     (pop),
    .rd_data (q_cmd),
    .stat    (q_stat)
  );

  tafd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .accel_gain (accel_gain),
    .time_gain  (time_gain),
    .q_cmd      (q_cmd),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .out_time   (out_time)
  );

  assign m_axis_tdata = {out_time, out_z, out_y, out_x};
  assign m_axis_tuser = out_status;

  // A job is never offered to a full queue, so none is lost.
  assert property (@(posedge clk) disable iff (rst) fe_stat.push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // Once halted, the classifier queues nothing more.
  assert property (@(posedge clk) disable iff (rst) fe_stat.halted |-> !fe_stat.push)
    else $error("job queued after halt");

  // Queue flags are never both set.
  assert property (@(posedge clk) disable iff (rst) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // An error job halts the classifier on the next edge.
  assert property (@(posedge clk) disable iff (rst)
      fe_stat.push && (fe_cmd.status != STATUS_SAMPLE) |=> fe_stat.halted)
    else $error("error job did not halt the classifier");

endmodule
